>>> hdl/assert_macros.svh
// Assertion macros shared by the validator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check on every clock edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check on every clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/svv_pkg.sv
// Types, character codes and sizes for the version string validator
package svv_pkg;

    localparam int NUMBER_BITS = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_V  = 8'h56;
    localparam logic [7:0] CH_LO_V  = 8'h76;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_VEE,
        CLS_LETTER,
        CLS_DASH,
        CLS_DOT,
        CLS_PLUS,
        CLS_OTHER
    } t_svv_cls;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_svv_in;

    typedef struct packed {
        t_svv_cls   cls;
        logic [3:0] dval;
        logic       last;
    } t_svv_tok;

    typedef struct packed {
        logic                   valid_res;
        logic [NUMBER_BITS-1:0] major;
        logic [NUMBER_BITS-1:0] minor;
        logic [NUMBER_BITS-1:0] patch;
        logic                   has_patch;
        logic                   has_prerelease;
        logic                   has_build;
    } t_svv_res;

endpackage

>>> hdl/svv_classify.sv
// Front end: accept a byte and reduce it to a character class and digit value
module svv_classify (
    input  logic              i_in_valid,
    input  svv_pkg::t_svv_in  i_in_data,
    output logic              o_in_ready,
    input  logic              i_full,
    output logic              o_push,
    output svv_pkg::t_svv_tok o_tok
);

    logic [7:0] ch;

    assign ch         = i_in_data.ch;
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_tok.dval = ch[3:0];
        o_tok.last = i_in_data.last;
        priority if (ch >= svv_pkg::CH_ZERO && ch <= svv_pkg::CH_NINE) begin
            o_tok.cls = svv_pkg::CLS_DIGIT;
        end else if (ch == svv_pkg::CH_LO_V || ch == svv_pkg::CH_UP_V) begin
            o_tok.cls = svv_pkg::CLS_VEE;
        end else if ((ch >= svv_pkg::CH_UP_A && ch <= svv_pkg::CH_UP_Z) ||
                     (ch >= svv_pkg::CH_LO_A && ch <= svv_pkg::CH_LO_Z)) begin
            o_tok.cls = svv_pkg::CLS_LETTER;
        end else if (ch == svv_pkg::CH_DASH) begin
            o_tok.cls = svv_pkg::CLS_DASH;
        end else if (ch == svv_pkg::CH_DOT) begin
            o_tok.cls = svv_pkg::CLS_DOT;
        end else if (ch == svv_pkg::CH_PLUS) begin
            o_tok.cls = svv_pkg::CLS_PLUS;
        end else begin
            o_tok.cls = svv_pkg::CLS_OTHER;
        end
    end

endmodule

>>> hdl/svv_queue.sv
// Short queue of classified bytes between the front end and the parser
`include "assert_macros.svh"

module svv_queue #(
    parameter int P_DEPTH = svv_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  svv_pkg::t_svv_tok i_wdata,
    output logic              o_full,
    input  logic              i_pop,
    output svv_pkg::t_svv_tok o_rdata,
    output logic              o_empty
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    svv_pkg::t_svv_tok r_mem [P_DEPTH];
    logic [PW-1:0]     r_wptr, n_wptr;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [CW-1:0]     r_count, n_count;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(P_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(P_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `ASSERT_RST(a_count_max, i_clk, i_rst_n, r_count <= CW'(P_DEPTH), "queue overfilled")
    `ASSERT_RST(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full, "push into full queue")
    `ASSERT_RST(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> !o_empty, "pop from empty queue")
    `ASSERT_RST(a_count_up, i_clk, i_rst_n,
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)), "count not advanced on push")

endmodule

>>> hdl/svv_parse.sv
// Back end: grammar state per byte and the registered result
`include "assert_macros.svh"

module svv_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  svv_pkg::t_svv_tok  i_tok,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output svv_pkg::t_svv_res  o_out_data
);

    localparam int NB = svv_pkg::NUMBER_BITS;

    localparam logic [3:0] PH_START     = 4'd0;
    localparam logic [3:0] PH_MAJ_FIRST = 4'd1;
    localparam logic [3:0] PH_MAJ       = 4'd2;
    localparam logic [3:0] PH_MIN_FIRST = 4'd3;
    localparam logic [3:0] PH_MIN       = 4'd4;
    localparam logic [3:0] PH_PAT_FIRST = 4'd5;
    localparam logic [3:0] PH_PAT       = 4'd6;
    localparam logic [3:0] PH_PRE       = 4'd7;
    localparam logic [3:0] PH_BUILD     = 4'd8;

    logic [3:0]    r_phase, n_phase;
    logic [NB-1:0] r_acc, n_acc;
    logic [NB-1:0] r_major, n_major;
    logic [NB-1:0] r_minor, n_minor;
    logic          r_patch_seen, n_patch_seen;
    logic          r_id_nonempty, n_id_nonempty;
    logic          r_id_first_zero, n_id_first_zero;
    logic          r_id_all_digits, n_id_all_digits;
    logic          r_id_multi, n_id_multi;
    logic          r_err, n_err;
    logic          r_pre_seen, n_pre_seen;
    logic          r_build_seen, n_build_seen;

    logic              r_out_valid;
    svv_pkg::t_svv_res r_out;
    svv_pkg::t_svv_res res;

    logic          dig, is_id, is_zero;
    logic [NB+3:0] prod;
    logic          ovf;
    logic          cur_idok_pre, cur_idok_build;
    logic          end_idok_pre, end_idok_build;
    logic          ok;
    logic          out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = !i_empty && (!i_tok.last || out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign dig     = (i_tok.cls == svv_pkg::CLS_DIGIT);
    assign is_zero = dig && (i_tok.dval == 4'd0);
    assign is_id   = dig || (i_tok.cls == svv_pkg::CLS_VEE) ||
                     (i_tok.cls == svv_pkg::CLS_LETTER) || (i_tok.cls == svv_pkg::CLS_DASH);
    assign prod    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {{NB{1'b0}}, i_tok.dval};
    assign ovf     = |prod[NB+3:NB];

    assign cur_idok_pre   = r_id_nonempty &&
                            !(r_id_first_zero && r_id_multi && r_id_all_digits);
    assign cur_idok_build = r_id_nonempty;

    always_comb begin
        n_phase         = r_phase;
        n_acc           = r_acc;
        n_major         = r_major;
        n_minor         = r_minor;
        n_patch_seen    = r_patch_seen;
        n_id_nonempty   = r_id_nonempty;
        n_id_first_zero = r_id_first_zero;
        n_id_all_digits = r_id_all_digits;
        n_id_multi      = r_id_multi;
        n_err           = r_err;
        n_pre_seen      = r_pre_seen;
        n_build_seen    = r_build_seen;
        if (!r_err) begin
            unique case (r_phase)
                PH_START, PH_MAJ_FIRST, PH_MIN_FIRST, PH_PAT_FIRST: begin
                    if (r_phase == PH_START && i_tok.cls == svv_pkg::CLS_VEE) begin
                        n_phase = PH_MAJ_FIRST;
                    end else if (dig) begin
                        n_id_nonempty   = 1'b1;
                        n_id_first_zero = is_zero;
                        n_id_all_digits = 1'b1;
                        n_id_multi      = 1'b0;
                        if (ovf) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc = prod[NB-1:0];
                        end
                        n_phase = (r_phase == PH_MIN_FIRST) ? PH_MIN :
                                  (r_phase == PH_PAT_FIRST) ? PH_PAT : PH_MAJ;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_MAJ, PH_MIN, PH_PAT: begin
                    if (dig) begin
                        if ((r_id_nonempty && r_id_first_zero) || ovf) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc = prod[NB-1:0];
                        end
                    end else if (r_phase == PH_MAJ && i_tok.cls == svv_pkg::CLS_DOT) begin
                        n_major = r_acc;
                        n_acc   = '0;
                        n_phase = PH_MIN_FIRST;
                    end else if (r_phase == PH_MIN && i_tok.cls == svv_pkg::CLS_DOT) begin
                        n_minor      = r_acc;
                        n_acc        = '0;
                        n_patch_seen = 1'b1;
                        n_phase      = PH_PAT_FIRST;
                    end else if (r_phase != PH_MAJ && (i_tok.cls == svv_pkg::CLS_DASH ||
                                 i_tok.cls == svv_pkg::CLS_PLUS)) begin
                        if (r_phase == PH_MIN) begin
                            n_minor = r_acc;
                            n_acc   = '0;
                        end
                        n_id_nonempty   = 1'b0;
                        n_id_first_zero = 1'b0;
                        n_id_all_digits = 1'b1;
                        n_id_multi      = 1'b0;
                        if (i_tok.cls == svv_pkg::CLS_DASH) begin
                            n_pre_seen = 1'b1;
                            n_phase    = PH_PRE;
                        end else begin
                            n_build_seen = 1'b1;
                            n_phase      = PH_BUILD;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_PRE, PH_BUILD: begin
                    if (i_tok.cls == svv_pkg::CLS_DOT ||
                        (r_phase == PH_PRE && i_tok.cls == svv_pkg::CLS_PLUS)) begin
                        if ((r_phase == PH_PRE) ? !cur_idok_pre : !cur_idok_build) begin
                            n_err = 1'b1;
                        end else begin
                            n_id_nonempty   = 1'b0;
                            n_id_first_zero = 1'b0;
                            n_id_all_digits = 1'b1;
                            n_id_multi      = 1'b0;
                            if (i_tok.cls == svv_pkg::CLS_PLUS) begin
                                n_build_seen = 1'b1;
                                n_phase      = PH_BUILD;
                            end
                        end
                    end else if (is_id) begin
                        if (!r_id_nonempty) begin
                            n_id_first_zero = is_zero;
                        end else begin
                            n_id_multi = 1'b1;
                        end
                        if (!dig) begin
                            n_id_all_digits = 1'b0;
                        end
                        n_id_nonempty = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: n_err = 1'b1;
            endcase
        end
    end

    assign end_idok_pre   = n_id_nonempty &&
                            !(n_id_first_zero && n_id_multi && n_id_all_digits);
    assign end_idok_build = n_id_nonempty;

    always_comb begin
        ok = !n_err && ((n_phase == PH_MIN) || (n_phase == PH_PAT) ||
                        (n_phase == PH_PRE && end_idok_pre) ||
                        (n_phase == PH_BUILD && end_idok_build));
        res = '0;
        if (ok) begin
            res.valid_res      = 1'b1;
            res.major          = n_major;
            res.minor          = (n_phase == PH_MIN) ? n_acc : n_minor;
            res.patch          = n_patch_seen ? n_acc : '0;
            res.has_patch      = n_patch_seen;
            res.has_prerelease = n_pre_seen;
            res.has_build      = n_build_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_tok.last)) begin
            r_phase         <= PH_START;
            r_acc           <= '0;
            r_major         <= '0;
            r_minor         <= '0;
            r_patch_seen    <= 1'b0;
            r_id_nonempty   <= 1'b0;
            r_id_first_zero <= 1'b0;
            r_id_all_digits <= 1'b1;
            r_id_multi      <= 1'b0;
            r_err           <= 1'b0;
            r_pre_seen      <= 1'b0;
            r_build_seen    <= 1'b0;
        end else if (o_pop) begin
            r_phase         <= n_phase;
            r_acc           <= n_acc;
            r_major         <= n_major;
            r_minor         <= n_minor;
            r_patch_seen    <= n_patch_seen;
            r_id_nonempty   <= n_id_nonempty;
            r_id_first_zero <= n_id_first_zero;
            r_id_all_digits <= n_id_all_digits;
            r_id_multi      <= n_id_multi;
            r_err           <= n_err;
            r_pre_seen      <= n_pre_seen;
            r_build_seen    <= n_build_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.last) begin
            r_out <= res;
        end
    end

    `ASSERT_RST(a_invalid_zero, i_clk, i_rst_n,
        (r_out_valid && !r_out.valid_res) |-> (r_out == '0), "invalid result carries fields")
    `ASSERT_RST(a_err_sticky, i_clk, i_rst_n,
        (r_err && !(o_pop && i_tok.last)) |=> r_err, "error cleared mid string")
    `ASSERT_RST(a_phase_legal, i_clk, i_rst_n, r_phase <= PH_BUILD, "phase out of range")

endmodule

>>> hdl/semver_string_validator_unit.sv
// Top level of the semantic version string validator
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  input   | in        | i_in_valid / o_in_ready  | i_in_data  (byte, last)
//  result  | out       | o_out_valid / i_out_ready| o_out_data (flag, numbers)
//
// One byte is taken every cycle while the queue is not full. The front end classifies
// each byte into a queue of P_QUEUE_DEPTH entries; the parser drains one entry a cycle,
// unless a last byte waits for the output register to free, and holds the result there.
// Reset is synchronous; the parser returns to the start of a string after each result.
// While a result waits, bytes of the next string keep flowing until the queue fills.
module semver_string_validator_unit #(
    parameter int P_QUEUE_DEPTH = svv_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  svv_pkg::t_svv_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output svv_pkg::t_svv_res o_out_data
);

    logic              push, pop, full, empty;
    svv_pkg::t_svv_tok wtok, rtok;

    svv_classify u_classify (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_full     (full),
        .o_push     (push),
        .o_tok      (wtok)
    );

    svv_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wtok),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (rtok),
        .o_empty (empty)
    );

    svv_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_tok       (rtok),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
